[hw/rtl/cwg_pkg.sv]
// Shared types, constants and helpers for the center-window gradient focus core.
package cwg_pkg;

    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    localparam int unsigned LUMA_W = 8;
    localparam int unsigned SUM_W  = 32;

    // Pixel beat as it leaves the front stage.
    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic [LUMA_W:0]   left_diff;
        logic              in_window;
        logic              clear_sum;
        logic              frame_end;
    } cwg_pix_t;

    // Floor division by three for values below 2^16 (reciprocal multiply).
    function automatic logic [15:0] div3(input logic [15:0] x);
        logic [32:0] prod;
        prod = {17'b0, x} * 33'd43691;
        return prod[32:17];
    endfunction

    function automatic logic [LUMA_W-1:0] abs_diff(input logic [LUMA_W-1:0] a,
                                                   input logic [LUMA_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

[hw/rtl/center_window_gradient_focus_sum_core.sv]
// Top level of the center-window absolute-gradient focus measure.
// A frame's sum passes the accumulate register into the result buffer that drives m_valid.
// Throughput: one pixel beat per cycle; s_ready is held low by a full two-entry result buffer,
// by an occupied output slot with a sum in flight, and in the cycle right after a config write or reset.
// Reset (aresetn, synchronous, active low): 640x480 geometry, counters, left pixel and sum
// cleared, result buffer emptied; line store contents stay undefined until written.
module center_window_gradient_focus_sum_core import cwg_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [LUMA_W-1:0]     s_luma,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SUM_W-1:0]      m_focus_sum
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);

    logic [WDW-1:0]    w_dim, w_lo, w_hi;
    logic [HDW-1:0]    h_dim, h_lo, h_hi;
    logic              cfg_busy;
    logic              out_room;
    logic              accept;

    logic [CW-1:0]     col_reg, col_next, col_eff;
    logic [RW-1:0]     row_reg, row_next, row_eff;
    logic [LUMA_W-1:0] left_reg;
    logic [CW:0]       col_inc;
    logic [RW:0]       row_inc;
    logic              row_wrap;
    logic              frame_end;
    logic              in_window;
    cwg_pix_t          pix;
    logic [LUMA_W-1:0] above;

    // Geometry and window bounds, registered behind the config port's frame-size registers.
    cwg_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WDW        (WDW),
        .HDW        (HDW)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .w_dim     (w_dim),
        .w_lo      (w_lo),
        .w_hi      (w_hi),
        .h_dim     (h_dim),
        .h_lo      (h_lo),
        .h_hi      (h_hi),
        .busy      (cfg_busy)
    );

    // Hold off input in the cycle after a write so the bounds settle.
    assign s_ready = out_room && !cfg_busy;
    assign accept  = s_valid && s_ready;

    // Frame start puts this pixel at row 0, column 0.
    always_comb begin
        col_eff   = s_frame_start ? '0 : col_reg;
        row_eff   = s_frame_start ? '0 : row_reg;
        in_window = (HDW'(row_eff) > h_lo) && (HDW'(row_eff) < h_hi)
                 && (WDW'(col_eff) > w_lo) && (WDW'(col_eff) < w_hi);
        col_inc   = {1'b0, col_eff} + (CW+1)'(1);
        row_inc   = {1'b0, row_eff} + (RW+1)'(1);
        // A column at or past the width ends the row, even after a resize.
        row_wrap  = col_inc >= (CW+1)'(w_dim);
        frame_end = row_wrap && (row_inc >= (RW+1)'(h_dim));
        col_next  = row_wrap ? '0 : col_inc[CW-1:0];
        if (!row_wrap) begin
            row_next = row_eff;
        end else if (frame_end) begin
            row_next = '0;
        end else begin
            row_next = row_inc[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= s_luma;
        end
    end

    // Horizontal gradient is ready now; vertical one waits for the line store read.
    always_comb begin
        pix.luma      = s_luma;
        pix.left_diff = {1'b0, abs_diff(s_luma, left_reg)};
        pix.in_window = in_window;
        pix.clear_sum = s_frame_start;
        pix.frame_end = frame_end;
    end

    // Read the pixel above and replace it with this one in the same cycle.
    cwg_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .aclk  (aclk),
        .en    (accept),
        .addr  (col_eff),
        .wdata (s_luma),
        .rdata (above)
    );

    // Add both gradients into the running sum and emit it at frame end.
    cwg_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pix_valid   (accept),
        .pix         (pix),
        .above       (above),
        .out_room    (out_room),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_focus_sum (m_focus_sum)
    );

endmodule

[hw/rtl/cwg_geom.sv]
// Geometry registers: frame size, clamped dimensions and center-window bounds.
module cwg_geom import cwg_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int WDW        = $clog2(MAX_WIDTH + 1),
    parameter int HDW        = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [WDW-1:0]        w_dim,
    output logic [WDW-1:0]        w_lo,
    output logic [WDW-1:0]        w_hi,
    output logic [HDW-1:0]        h_dim,
    output logic [HDW-1:0]        h_lo,
    output logic [HDW-1:0]        h_hi,
    output logic                  busy
);

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [31:0]           w_ext, h_ext, w_c, h_c;
    logic [15:0]           w_lo_q, w_hi_q, h_lo_q, h_hi_q;
    logic [WDW-1:0]        w_dim_reg, w_lo_reg, w_hi_reg;
    logic [HDW-1:0]        h_dim_reg, h_lo_reg, h_hi_reg;
    logic                  busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
            busy_reg   <= 1'b1;
        end else begin
            busy_reg <= cfg_we;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                    REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                endcase
            end
        end
    end

    // Treat zero as one and cap at the buffer limits.
    always_comb begin
        w_ext = 32'(width_reg);
        h_ext = 32'(height_reg);
        if (w_ext == 32'd0)                w_c = 32'd1;
        else if (w_ext > 32'(MAX_WIDTH))   w_c = 32'(MAX_WIDTH);
        else                               w_c = w_ext;
        if (h_ext == 32'd0)                h_c = 32'd1;
        else if (h_ext > 32'(MAX_HEIGHT))  h_c = 32'(MAX_HEIGHT);
        else                               h_c = h_ext;
        w_lo_q = div3(w_c[15:0]);
        w_hi_q = div3({w_c[14:0], 1'b0});
        h_lo_q = div3(h_c[15:0]);
        h_hi_q = div3({h_c[14:0], 1'b0});
    end

    always_ff @(posedge aclk) begin
        w_dim_reg <= w_c[WDW-1:0];
        w_lo_reg  <= w_lo_q[WDW-1:0];
        w_hi_reg  <= w_hi_q[WDW-1:0];
        h_dim_reg <= h_c[HDW-1:0];
        h_lo_reg  <= h_lo_q[HDW-1:0];
        h_hi_reg  <= h_hi_q[HDW-1:0];
    end

    assign w_dim = w_dim_reg;
    assign w_lo  = w_lo_reg;
    assign w_hi  = w_hi_reg;
    assign h_dim = h_dim_reg;
    assign h_lo  = h_lo_reg;
    assign h_hi  = h_hi_reg;
    assign busy  = busy_reg;

endmodule

[hw/rtl/cwg_line_buf.sv]
// Single-port read-first line store holding the previous row of luma.
module cwg_line_buf import cwg_pkg::*; #(
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [AW-1:0]     addr,
    input  logic [LUMA_W-1:0] wdata,
    output logic [LUMA_W-1:0] rdata
);

    logic [LUMA_W-1:0] mem [DEPTH];
    logic [LUMA_W-1:0] rdata_reg;

    // Return the old entry, then overwrite it with the current pixel.
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/cwg_accum.sv]
// Gradient accumulate stage and two-entry result buffer.
module cwg_accum import cwg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pix_valid,
    input  cwg_pix_t          pix,
    input  logic [LUMA_W-1:0] above,
    output logic              out_room,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SUM_W-1:0]  m_focus_sum
);

    logic              p1_valid_reg;
    cwg_pix_t          p1_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [LUMA_W:0]   above_diff;
    logic [LUMA_W+1:0] grad;
    logic              push, pop;
    logic              out_valid_reg, skid_valid_reg;
    logic [SUM_W-1:0]  out_data_reg, skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_valid) begin
            p1_reg <= pix;
        end
    end

    always_comb begin
        above_diff = {1'b0, abs_diff(p1_reg.luma, above)};
        grad       = {1'b0, above_diff} + {1'b0, p1_reg.left_diff};
        sum_next   = (p1_reg.clear_sum ? '0 : sum_reg)
                   + (p1_reg.in_window ? SUM_W'(grad) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (p1_valid_reg) begin
            sum_reg <= p1_reg.frame_end ? '0 : sum_next;
        end
    end

    assign push = p1_valid_reg && p1_reg.frame_end;
    assign pop  = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= push;
            end else begin
                out_valid_reg <= push;
            end
        end else if (!out_valid_reg) begin
            out_valid_reg <= push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_valid_reg) begin
            out_data_reg  <= skid_data_reg;
            skid_data_reg <= sum_next;
        end else if (pop || !out_valid_reg) begin
            out_data_reg <= sum_next;
        end else if (push) begin
            skid_data_reg <= sum_next;
        end
    end

    // A new beat may end a frame; keep a slot for it and any result in flight.
    assign out_room    = !skid_valid_reg && !(out_valid_reg && push);
    assign m_valid     = out_valid_reg;
    assign m_focus_sum = out_data_reg;

endmodule

[hw/rtl/cwg_checker.sv]
// Port-level assertions for the focus core, bound to the top level.
module cwg_checker import cwg_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             cfg_we,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [SUM_W-1:0] m_focus_sum
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_focus_sum))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_cfg_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("pixel beat taken right after a register write");

    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a pixel beat two cycles earlier");

endmodule

bind center_window_gradient_focus_sum_core cwg_checker u_cwg_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_we      (cfg_we),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_focus_sum (m_focus_sum)
);

[bench/testbench.sv]
// Self-checking bench for the center-window gradient focus core: directed frames, then random.
module testbench;
    import cwg_pkg::*;

    localparam int unsigned MAX_W         = 2048;
    localparam int unsigned MAX_H         = 2048;
    // Pipeline settle time after the last pixel beat, with a margin on top.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_PIXELS = 1150;
    localparam int unsigned ROUND_PIXELS  = 96;
    localparam int unsigned MIN_FRAMES    = 48;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int unsigned {
        PAT_ZERO,
        PAT_FULL,
        PAT_CHECKER,
        PAT_NOISE
    } luma_pattern_t;

    // Clock, reset and every block input start at known values.
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [LUMA_W-1:0]     s_luma        = '0;
    logic                  s_frame_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b1;
    logic [SUM_W-1:0]      m_focus_sum;

    // Idle rates of both sides, in percent of cycles.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned pixels_sent    = 0;
    int unsigned frames_done    = 0;

    // Predictor state: geometry as written, previous row, left pixel, counters, sum.
    logic [CFG_DATA_W-1:0] geo_width    = FRAME_WIDTH_RST;
    logic [CFG_DATA_W-1:0] geo_height   = FRAME_HEIGHT_RST;
    logic [LUMA_W-1:0]     prev_row [MAX_W] = '{default: '0};
    logic [LUMA_W-1:0]     left_luma    = '0;
    int unsigned           col_pos      = 0;
    int unsigned           row_pos      = 0;
    logic [SUM_W-1:0]      gradient_sum = '0;
    logic [SUM_W-1:0]      expected_sums [$];

    center_window_gradient_focus_sum_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_luma        (s_luma),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_focus_sum   (m_focus_sum)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stall the result side at the current rate; one draw per cycle.
    always @(posedge aclk) begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // A register value of zero acts as one, anything past the maximum as the maximum.
    function automatic int unsigned effective_dim(input logic [CFG_DATA_W-1:0] value,
                                                  input int unsigned limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic logic [SUM_W-1:0] luma_gap(input logic [LUMA_W-1:0] a,
                                                  input logic [LUMA_W-1:0] b);
        return (a >= b) ? SUM_W'(a - b) : SUM_W'(b - a);
    endfunction

    function automatic int unsigned pixels_per_frame();
        return effective_dim(geo_width, MAX_W) * effective_dim(geo_height, MAX_H);
    endfunction

    // Advance the predictor by one accepted pixel; queue the sum at a frame end.
    function automatic void accumulate_pixel(input logic [LUMA_W-1:0] luma,
                                             input logic fs);
        int unsigned       w;
        int unsigned       h;
        logic [LUMA_W-1:0] above;
        w = effective_dim(geo_width, MAX_W);
        h = effective_dim(geo_height, MAX_H);
        // Frame start clears counters and sum before the pixel counts as row 0, column 0.
        if (fs) begin
            col_pos      = 0;
            row_pos      = 0;
            gradient_sum = '0;
        end
        above = prev_row[col_pos];
        if (row_pos > h / 3 && row_pos < (2 * h) / 3 &&
            col_pos > w / 3 && col_pos < (2 * w) / 3) begin
            gradient_sum = gradient_sum + luma_gap(luma, above) + luma_gap(luma, left_luma);
        end
        prev_row[col_pos] = luma;
        left_luma         = luma;
        // Compare against the current geometry: a column past a shrunk width ends the row.
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
                expected_sums.push_back(gradient_sum);
                gradient_sum = '0;
                frames_done++;
            end
        end
    endfunction

    function automatic logic [LUMA_W-1:0] rand_luma();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return LUMA_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                   input logic [SUM_W-1:0] want);
        $display("mismatch at cycle %0d: %s, got %h, want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Check each result beat against the oldest queued sum.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0)
                report_mismatch("focus sum with none pending", m_focus_sum, '0);
            else if (m_focus_sum !== expected_sums[0])
                report_mismatch("focus_sum", m_focus_sum, expected_sums.pop_front());
            else
                void'(expected_sums.pop_front());
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER)   ? 54 : (mode == IDLE_BOTH) ? 14 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 54 : (mode == IDLE_BOTH) ? 14 : 0;
    endtask

    // Send one pixel beat; keep valid high across back-to-back beats.
    task automatic send_pixel(input logic [LUMA_W-1:0] luma, input logic fs);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_luma        <= luma;
        s_frame_start <= fs;
        do @(posedge aclk); while (s_ready !== 1'b1);
        accumulate_pixel(luma, fs);
        pixels_sent++;
    endtask

    task automatic send_frame(input int unsigned count, input logic with_start);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(rand_luma(), with_start && (i == 0));
    endtask

    // Drop valid, let every pending sum drain, then give the pipeline time to settle.
    task automatic wait_for_sums();
        s_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_for_sums();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            geo_width = value;
        else
            geo_height = value;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] width,
                                input logic [CFG_DATA_W-1:0] height);
        write_register(REG_FRAME_WIDTH, width);
        write_register(REG_FRAME_HEIGHT, height);
    endtask

    // Run on the 640x480 reset geometry without a frame start, then shrink it mid-frame.
    task automatic test_reset_geometry();
        set_idle(IDLE_NONE);
        // Fill row 0 at 640 wide and stop five pixels into row 1.
        send_frame(645, 1'b0);
        // Narrow to 5: the column count already sits at the new width and ends the row.
        write_register(REG_FRAME_WIDTH, 5);
        // Enter the 480-row window, rows 161..319, and stop inside row 300.
        while (row_pos < 300)
            send_pixel(rand_luma(), 1'b0);
        send_frame(2, 1'b0);
        // Cut the height below the current row: the end of this row ends the frame.
        write_register(REG_FRAME_HEIGHT, 200);
        while (row_pos != 0 || col_pos != 0)
            send_pixel(rand_luma(), 1'b0);
    endtask

    // Flat, full-scale and checkerboard frames hit the gradient extremes; a random frame follows.
    task automatic test_luma_extremes();
        luma_pattern_t     pattern;
        logic [LUMA_W-1:0] luma;
        set_idle(IDLE_BOTH);
        set_geometry(9, 9);
        for (int p = 0; p <= int'(PAT_NOISE); p++) begin
            pattern = luma_pattern_t'(p);
            for (int i = 0; i < 81; i++) begin
                case (pattern)
                    PAT_ZERO:    luma = '0;
                    PAT_FULL:    luma = '1;
                    PAT_CHECKER: luma = (((i / 9) + (i % 9)) % 2 != 0) ? '1 : '0;
                    default:     luma = rand_luma();
                endcase
                send_pixel(luma, i == 0);
            end
        end
    endtask

    // Abandon frames partway, inside the window too, and restart on a frame start.
    task automatic test_frame_resync();
        set_idle(IDLE_SENDER);
        send_frame(40, 1'b1);
        send_frame(81, 1'b1);
        send_frame(30, 1'b0);
        send_frame(81, 1'b1);
    endtask

    // Zero and oversize register values, and the largest widths and heights.
    task automatic test_dim_clamping();
        set_idle(IDLE_RECEIVER);
        // Zero acts as one: every pixel closes a 1x1 frame, with or without a start.
        set_geometry(0, 0);
        repeat (6)
            send_pixel(rand_luma(), 1'($urandom_range(0, 1)));
        set_geometry(4095, 5);
        send_frame(MAX_W * 5, 1'b1);
        set_geometry(5, 4095);
        send_frame(5 * MAX_H, 1'b1);
        set_geometry(2048, 1);
        send_frame(MAX_W, 1'b1);
        set_geometry(1, 2048);
        send_frame(MAX_H, 1'b1);
    endtask

    // Mostly well-formed frames on small random geometries, mixed with broken sequences.
    task automatic test_random_frames();
        int unsigned first_pixel;
        int unsigned first_frame;
        int unsigned round_idx;
        int unsigned round_end;
        int unsigned frame_len;
        first_pixel = pixels_sent;
        first_frame = frames_done;
        round_idx   = 0;
        while (pixels_sent - first_pixel < RANDOM_PIXELS ||
               frames_done - first_frame < MIN_FRAMES) begin
            set_idle(idle_mode_t'(round_idx % 4));
            set_geometry($urandom_range(0, 12), $urandom_range(0, 12));
            frame_len = pixels_per_frame();
            // Open every round on a frame start so no unwritten line entry is ever read.
            send_frame(frame_len, 1'b1);
            round_end = pixels_sent + ROUND_PIXELS;
            while (pixels_sent < round_end) begin
                case ($urandom_range(0, 9))
                    7: send_frame($urandom_range(1, frame_len), 1'b1);
                    8: begin
                        repeat ($urandom_range(1, 2 * frame_len))
                            send_pixel(rand_luma(), $urandom_range(0, 3) == 0);
                    end
                    9: send_frame($urandom_range(1, frame_len), 1'b0);
                    default: send_frame(frame_len, 1'b1);
                endcase
            end
            round_idx++;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_geometry();
        test_luma_extremes();
        test_frame_resync();
        test_dim_clamping();
        test_random_frames();
        // Hold the input idle until the last sum is in and the pipeline has settled.
        wait_for_sums();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
